### design/lzfh_pkg.sv
`default_nettype none

package lzfh_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam int LL_BINS  = 513;
  localparam int LL_AW    = $clog2(LL_BINS);
  localparam int NIB_BINS = 16;
  localparam int NIB_AW   = $clog2(NIB_BINS);
  localparam int NIB_TABS = 4;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam logic [LL_AW-1:0] LEN_BASE    = LL_AW'(256);
  localparam logic [LL_AW-1:0] EOI_BIN     = LL_AW'(512);
  localparam logic [LL_AW-1:0] LL_LAST_BIN = LL_AW'(LL_BINS - 1);
  localparam logic [9:0]       LL_BINS_V   = 10'(LL_BINS);
  localparam logic [9:0]       NIB_BINS_V  = 10'(NIB_BINS);

  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_EOI   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_DIST = 2'd2;
  localparam logic [1:0] ST_BIN  = 2'd3;

  localparam logic [2:0] TAB_LL   = 3'd0;
  localparam logic [2:0] TAB_NIB0 = 3'd1;
  localparam logic [2:0] TAB_NIB1 = 3'd2;
  localparam logic [2:0] TAB_NIB2 = 3'd3;
  localparam logic [2:0] TAB_NIB3 = 3'd4;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [9:0]  read_bin;
    logic [2:0]  read_table;
    logic [15:0] distance;
    logic [7:0]  match_length;
    logic [7:0]  byte_value;
  } lzfh_in_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } lzfh_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } lzfh_sts_t;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

### design/lzfh_ctrl.sv
`default_nettype none

module lzfh_ctrl
  import lzfh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire lzfh_sts_t sts,
  output lzfh_cmd_t      cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd.clear   = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

endmodule

`default_nettype wire

### design/lzfh_datapath.sv
`default_nettype none

module lzfh_datapath
  import lzfh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lzfh_cmd_t             cmd,
  output lzfh_sts_t                  sts,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [OUT_USER_W-1:0]      m_axis_tuser
);

  lzfh_in_t   in_item;
  lzfh_in_t   item;
  logic [1:0] op;

  logic [LL_AW-1:0]  clr_addr;
  logic [LL_AW-1:0]  ll_raddr;
  logic [LL_AW-1:0]  ll_addr;
  logic [LL_AW-1:0]  ll_waddr;
  count_t            ll_wdata;
  logic              ll_we;
  count_t            ll_mem [LL_BINS];
  count_t            ll_rdata;

  logic [NIB_AW-1:0] nib_raddr [NIB_TABS];
  logic [NIB_AW-1:0] nib_addr  [NIB_TABS];
  count_t            nib_mem   [NIB_TABS][NIB_BINS];
  count_t            nib_rdata [NIB_TABS];
  logic              nib_we;

  logic   ll_inc;
  logic   nib_inc;
  logic   bad_read;
  logic [1:0] status;
  count_t count;

  assign in_item = lzfh_in_t'(s_axis_tdata);

  always_comb begin
    ll_raddr = '0;
    unique case (s_axis_tuser)
      OP_LIT:   ll_raddr = LL_AW'(in_item.byte_value);
      OP_MATCH: ll_raddr = LEN_BASE + LL_AW'(in_item.match_length);
      OP_EOI:   ll_raddr = EOI_BIN;
      OP_READ: begin
        if (in_item.read_bin < LL_BINS_V) begin
          ll_raddr = LL_AW'(in_item.read_bin);
        end
      end
      default:  ll_raddr = '0;
    endcase
  end

  for (genvar t = 0; t < NIB_TABS; t++) begin : g_nib_raddr
    assign nib_raddr[t] = (s_axis_tuser == OP_READ) ? in_item.read_bin[NIB_AW-1:0]
                                                    : in_item.distance[t*NIB_AW +: NIB_AW];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item    <= in_item;
      op      <= s_axis_tuser;
      ll_addr <= ll_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clear_last = (clr_addr == LL_LAST_BIN);

  assign ll_inc  = (op == OP_LIT) || (op == OP_EOI) ||
                   ((op == OP_MATCH) && (item.match_length != '0));
  assign nib_inc = (op == OP_MATCH) && (item.match_length != '0) && (item.distance != '0);

  assign ll_we    = cmd.clear || (cmd.update && ll_inc);
  assign ll_waddr = cmd.clear ? clr_addr : ll_addr;
  assign ll_wdata = cmd.clear ? '0 : sat_inc(ll_rdata);
  assign nib_we   = cmd.clear || (cmd.update && nib_inc);

  always_ff @(posedge clk) begin
    if (ll_we) begin
      ll_mem[ll_waddr] <= ll_wdata;
    end
    if (cmd.capture) begin
      ll_rdata <= ll_mem[ll_raddr];
    end
  end

  for (genvar t = 0; t < NIB_TABS; t++) begin : g_nib_mem
    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        nib_addr[t]  <= nib_raddr[t];
        nib_rdata[t] <= nib_mem[t][nib_raddr[t]];
      end
    end

    always_ff @(posedge clk) begin
      if (nib_we) begin
        nib_mem[t][cmd.clear ? clr_addr[NIB_AW-1:0] : nib_addr[t]] <=
          cmd.clear ? '0 : sat_inc(nib_rdata[t]);
      end
    end
  end

  assign bad_read = (item.read_table == TAB_LL) ? (item.read_bin >= LL_BINS_V)
                  : ((item.read_table > TAB_NIB3) || (item.read_bin >= NIB_BINS_V));

  always_comb begin
    status = ST_OK;
    count  = '0;
    unique case (op)
      OP_MATCH: begin
        if (item.match_length == '0) begin
          status = ST_LEN;
        end else if (item.distance == '0) begin
          status = ST_DIST;
        end
      end
      OP_READ: begin
        if (bad_read) begin
          status = ST_BIN;
        end else begin
          case (item.read_table)
            TAB_LL:   count = ll_rdata;
            TAB_NIB0: count = nib_rdata[0];
            TAB_NIB1: count = nib_rdata[1];
            TAB_NIB2: count = nib_rdata[2];
            TAB_NIB3: count = nib_rdata[3];
            default:  count = '0;
          endcase
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.update) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      m_axis_tdata <= OUT_DATA_W'(count);
      m_axis_tuser <= status;
    end
  end

  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

endmodule

`default_nettype wire

### design/lz_token_frequency_histogram_unit.sv
// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   byte_value[7:0] match_length[15:8] distance[31:16]     opcode[1:0]
//                read_table[34:32] read_bin[44:35], zero fill to 48
// m_axis    out  bin_count[31:0]                                       status[1:0]
//
// In the accept cycle the count memories are read; the update state then increments,
// writes back and loads the result register once the result register is free.
// After reset a clearing pass zeroes all tables; s_axis_tready stays low during it.
// The result register holds while m_axis stalls; the next transaction is still accepted,
// and its write-back waits until the result register frees.
`default_nettype none

module lz_token_frequency_histogram_unit
  import lzfh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // byte_value, match_length, distance, read_table, read_bin
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // bin_count
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [OUT_USER_W-1:0]      m_axis_tuser
);

  lzfh_cmd_t cmd;
  lzfh_sts_t sts;

  lzfh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  lzfh_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### design/lzfh_checker.sv
`default_nettype none

module lzfh_checker
  import lzfh_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [IN_USER_W-1:0]  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!s_axis_tready && !m_axis_tvalid))
    else $error("ready or valid during clearing pass");

  a_error_zero_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("nonzero count with error status");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without pending transaction");

endmodule

bind lz_token_frequency_histogram_unit lzfh_checker u_lzfh_checker (.*);

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench
  import lzfh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TOKENS = 1500;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    count_t     bin_count;
    logic [1:0] status;
  } reply_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  byte_value;
    logic [7:0]  match_length;
    logic [15:0] distance;
    logic [2:0]  read_table;
    logic [9:0]  read_bin;
    logic        fixed;
    count_t      want_count;
    logic [1:0]  want_status;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  count_t ll_hist [LL_BINS];
  count_t nib_hist [NIB_TABS][NIB_BINS];
  reply_t expected_replies [$];

  int  errors = 0;
  int  cycles = 0;
  int  tokens_sent = 0;
  int  replies_checked = 0;
  int  reads_nonzero = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;

  plan_row_t plan [25] = '{
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd0,    1'b1, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_NIB3, 10'd15,   1'b1, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd512,  1'b1, 32'd0, ST_OK},
    '{OP_LIT,   8'd0,   8'd0,   16'd0,     TAB_LL,   10'd0,    1'b1, 32'd0, ST_OK},
    '{OP_LIT,   8'd255, 8'd0,   16'd0,     TAB_LL,   10'd0,    1'b1, 32'd0, ST_OK},
    '{OP_MATCH, 8'd0,   8'd1,   16'd1,     TAB_LL,   10'd0,    1'b1, 32'd0, ST_OK},
    '{OP_MATCH, 8'd0,   8'd255, 16'hffff,  TAB_LL,   10'd0,    1'b1, 32'd0, ST_OK},
    '{OP_MATCH, 8'd0,   8'd0,   16'd100,   TAB_LL,   10'd0,    1'b1, 32'd0, ST_LEN},
    '{OP_MATCH, 8'd0,   8'd3,   16'd0,     TAB_LL,   10'd0,    1'b1, 32'd0, ST_DIST},
    '{OP_EOI,   8'd0,   8'd0,   16'd0,     TAB_LL,   10'd0,    1'b1, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd0,    1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd255,  1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd256,  1'b1, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd257,  1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd259,  1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd511,  1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd512,  1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_NIB0, 10'd1,    1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_NIB3, 10'd15,   1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_NIB1, 10'd0,    1'b0, 32'd0, ST_OK},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd513,  1'b1, 32'd0, ST_BIN},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_NIB0, 10'd16,   1'b1, 32'd0, ST_BIN},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     3'd5,     10'd0,    1'b1, 32'd0, ST_BIN},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     3'd7,     10'd1023, 1'b1, 32'd0, ST_BIN},
    '{OP_READ,  8'd0,   8'd0,   16'd0,     TAB_LL,   10'd1023, 1'b1, 32'd0, ST_BIN}
  };

  lz_token_frequency_histogram_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (ll_hist[i]) ll_hist[i] = '0;
    foreach (nib_hist[t, b]) nib_hist[t][b] = '0;
  end

  function automatic count_t saturate_up(count_t v);
    if (v != '1) v = v + 1'b1;
    return v;
  endfunction

  function automatic reply_t histogram_reply(logic [1:0] op, lzfh_in_t f);
    reply_t r;
    int     k;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_LIT: begin
        ll_hist[f.byte_value] = saturate_up(ll_hist[f.byte_value]);
      end
      OP_MATCH: begin
        if (f.match_length == 8'd0) begin
          r.status = ST_LEN;
        end else begin
          k = int'(LEN_BASE) + int'(f.match_length);
          ll_hist[k] = saturate_up(ll_hist[k]);
          if (f.distance == 16'd0) begin
            r.status = ST_DIST;
          end else begin
            for (k = 0; k < NIB_TABS; k++)
              nib_hist[k][f.distance[4*k +: 4]] = saturate_up(nib_hist[k][f.distance[4*k +: 4]]);
          end
        end
      end
      OP_EOI: begin
        ll_hist[EOI_BIN] = saturate_up(ll_hist[EOI_BIN]);
      end
      default: begin
        if (f.read_table == TAB_LL) begin
          if (f.read_bin < LL_BINS_V) r.bin_count = ll_hist[f.read_bin];
          else r.status = ST_BIN;
        end else if (f.read_table <= TAB_NIB3 && f.read_bin < NIB_BINS_V) begin
          r.bin_count = nib_hist[f.read_table - TAB_NIB0][f.read_bin[3:0]];
        end else begin
          r.status = ST_BIN;
        end
        if (r.bin_count != '0) reads_nonzero++;
      end
    endcase
    return r;
  endfunction

  task automatic random_token(output logic [1:0] op, output lzfh_in_t f);
    int pick;
    f = '0;
    f.byte_value   = 8'($urandom);
    f.match_length = 8'($urandom);
    f.distance     = 16'($urandom);
    f.read_table   = 3'($urandom);
    f.read_bin     = 10'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = OP_LIT;
    end else if (pick < 70) begin
      op = OP_MATCH;
      f.match_length = ($urandom_range(0, 29) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      if ($urandom_range(0, 29) == 0) f.distance = 16'd0;
      else if ($urandom_range(0, 3) == 0) f.distance = 16'($urandom_range(1, 15));
      else f.distance = 16'($urandom_range(1, 65535));
    end else if (pick < 75) begin
      op = OP_EOI;
    end else begin
      op = OP_READ;
      if ($urandom_range(0, 9) != 0) begin
        f.read_table = 3'($urandom_range(0, 4));
        f.read_bin = (f.read_table == TAB_LL) ? 10'($urandom_range(0, 512))
                                              : 10'($urandom_range(0, 15));
      end
    end
  endtask

  task automatic send_token(logic [1:0] op, lzfh_in_t f, logic fixed, reply_t fixed_reply);
    int     gap;
    reply_t want;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    want = histogram_reply(op, f);
    expected_replies.push_back(fixed ? fixed_reply : want);
    tokens_sent++;
    @(negedge clk);
  endtask

  always begin
    int stall;
    stall = recv_calm ? 0 : $urandom_range(0, 8);
    if (stall > 0) begin
      m_axis_tready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    m_axis_tready <= 1'b1;
    do @(posedge clk); while (!(m_axis_tvalid && !rst));
    if (replies_checked % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected transaction: bin_count %0d status %0d", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata !== want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", want.bin_count, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          errors++;
        end
        status_seen[want.status]++;
        replies_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] op;
    lzfh_in_t   f;
    reply_t     typed;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      f = '0;
      f.byte_value   = plan[i].byte_value;
      f.match_length = plan[i].match_length;
      f.distance     = plan[i].distance;
      f.read_table   = plan[i].read_table;
      f.read_bin     = plan[i].read_bin;
      typed.bin_count = plan[i].want_count;
      typed.status    = plan[i].want_status;
      send_token(plan[i].op, f, plan[i].fixed, typed);
    end

    for (int i = 0; i < RANDOM_TOKENS; i++) begin
      if (i % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
      random_token(op, f);
      send_token(op, f, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) errors++;

    $display("%0d tokens sent, %0d replies checked, %0d bin reads returned a nonzero count",
             tokens_sent, replies_checked, reads_nonzero);
    $display("status mix: ok %0d, bad length %0d, bad distance %0d, bad bin %0d",
             status_seen[ST_OK], status_seen[ST_LEN], status_seen[ST_DIST], status_seen[ST_BIN]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
